[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define AOPC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked around reset.
`define AOPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/aopc_pkg.sv]
// Types, constants and arithmetic helpers of the alpha-over pixel compositor.
package aopc_pkg;

	localparam int NCHAN = 3;
	localparam int NUM_W = 18;
	localparam int QBITS = 8;
	localparam logic [7:0] FULL_SCALE = 8'd255;
	localparam logic [7:0] HALF_ROUND = 8'd127;

	typedef enum logic [1:0] {
		MODE_PASS,
		MODE_SRC,
		MODE_BLEND
	} mode_t;

	typedef struct packed {
		logic [7:0] mask;
		logic [7:0] trans;
		logic [NCHAN-1:0][7:0] src;
		logic [NCHAN-1:0][7:0] dst;
		logic [7:0] da;
	} pix_t;

	typedef struct packed {
		logic [NCHAN-1:0][NUM_W-1:0] rem;
		logic [NCHAN-1:0][QBITS-1:0] q;
		logic [NCHAN-1:0] sat;
		logic [8:0] ao;
		mode_t mode;
		logic [NCHAN-1:0][7:0] src;
		logic [NCHAN-1:0][7:0] dst;
		logic [7:0] sa;
		logic [7:0] da;
	} cw_t;

	// Exact floor(x / 255) for x up to 65279, where the quotient fits in a byte.
	function automatic logic [7:0] div255_16(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'(x >> 8) + 17'd1;
		return t[15:8];
	endfunction

	// Exact floor(x / 255) for a 24-bit value whose quotient fits in 16 bits: estimate, then correct by remainder.
	function automatic logic [15:0] div255_24(input logic [23:0] x);
		logic [23:0] q0;
		logic [25:0] t;
		logic [10:0] r;
		logic [1:0] c;
		q0 = 24'(x >> 8) + 24'(x >> 16);
		t = {2'b00, x} - ((26'(q0) << 8) - 26'(q0));
		r = t[10:0];
		c = 2'(r >= 11'd255) + 2'(r >= 11'd510) + 2'(r >= 11'd765);
		return 16'(q0 + 24'(c));
	endfunction

endpackage

[rtl/aopc_front.sv]
// Front pipeline: source alpha, result alpha, the blend numerators, saturation flags and the blend mode.
module aopc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  aopc_pkg::pix_t in_pix,
	output logic          take,
	input  logic          dn_take,
	output logic          valid_s6,
	output aopc_pkg::cw_t word_s6
);
	import aopc_pkg::*;

	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic e1, e2, e3, e4, e5, e6;

	pix_t pix_s1, pix_s2, pix_s3, pix_s4, pix_s5;
	logic [15:0] ma_s1;
	logic [7:0] sa_s2, sa_s3, sa_s4, sa_s5;
	logic [15:0] p_s3;
	logic [NCHAN-1:0][15:0] csa_s3, cdd_s3, csa_s4, cdd_s4;
	logic [NCHAN-1:0][23:0] x_s4;
	logic [8:0] ao_s4, ao_s5;
	logic [NCHAN-1:0][NUM_W-1:0] num_s5;
	logic [NCHAN-1:0][NUM_W-1:0] num_d;
	logic [NCHAN-1:0] sat_d;
	mode_t mode_d;

	assign e6 = !valid_s6 || dn_take;
	assign e5 = !v5_q || e6;
	assign e4 = !v4_q || e5;
	assign e3 = !v3_q || e4;
	assign e2 = !v2_q || e3;
	assign e1 = !v1_q || e2;
	assign take = e1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (e1) v1_q <= in_valid;
			if (e2) v2_q <= v1_q;
			if (e3) v3_q <= v2_q;
			if (e4) v4_q <= v3_q;
			if (e5) v5_q <= v4_q;
			if (e6) valid_s6 <= v5_q;
		end
	end

	always_ff @(posedge clk) begin
		if (e1) begin
			pix_s1 <= in_pix;
			ma_s1 <= 16'(in_pix.mask) * 16'(FULL_SCALE - in_pix.trans);
		end
	end

	always_ff @(posedge clk) begin
		if (e2) begin
			pix_s2 <= pix_s1;
			sa_s2 <= div255_16(ma_s1 + 16'(HALF_ROUND));
		end
	end

	always_ff @(posedge clk) begin
		if (e3) begin
			pix_s3 <= pix_s2;
			sa_s3 <= sa_s2;
			p_s3 <= 16'(sa_s2) * 16'(pix_s2.da);
			for (int c = 0; c < NCHAN; c++) begin
				csa_s3[c] <= 16'(pix_s2.src[c]) * 16'(sa_s2);
				cdd_s3[c] <= 16'(pix_s2.dst[c]) * 16'(pix_s2.da);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (e4) begin
			pix_s4 <= pix_s3;
			sa_s4 <= sa_s3;
			ao_s4 <= 9'(sa_s3) + 9'(pix_s3.da) - 9'(div255_16(p_s3 + 16'(HALF_ROUND)));
			csa_s4 <= csa_s3;
			cdd_s4 <= cdd_s3;
			for (int c = 0; c < NCHAN; c++) begin
				x_s4[c] <= 24'(cdd_s3[c]) * 24'(sa_s3);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (e5) begin
			pix_s5 <= pix_s4;
			sa_s5 <= sa_s4;
			ao_s5 <= ao_s4;
			for (int c = 0; c < NCHAN; c++) begin
				num_s5[c] <= NUM_W'(csa_s4[c]) + NUM_W'(cdd_s4[c])
					- NUM_W'(div255_24(x_s4[c])) + NUM_W'(ao_s4 >> 1);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < NCHAN; c++) begin
			num_d[c] = num_s5[c];
			sat_d[c] = num_s5[c] >= (NUM_W'(ao_s5) << QBITS);
		end
		if (sa_s5 == 8'd0) begin
			mode_d = MODE_PASS;
		end else if (pix_s5.da == 8'd0) begin
			mode_d = MODE_SRC;
		end else if (ao_s5 == 9'd0) begin
			mode_d = MODE_PASS;
		end else begin
			mode_d = MODE_BLEND;
		end
	end

	always_ff @(posedge clk) begin
		if (e6) begin
			word_s6.rem <= num_d;
			word_s6.q <= '0;
			word_s6.sat <= sat_d;
			word_s6.ao <= ao_s5;
			word_s6.mode <= mode_d;
			word_s6.src <= pix_s5.src;
			word_s6.dst <= pix_s5.dst;
			word_s6.sa <= sa_s5;
			word_s6.da <= pix_s5.da;
		end
	end

endmodule

[rtl/aopc_div_cell.sv]
// One restoring-division cell: settles one quotient bit for all three channels.
module aopc_div_cell #(
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  aopc_pkg::cw_t in_word,
	output logic          take,
	input  logic          dn_take,
	output logic          valid_q,
	output aopc_pkg::cw_t word_q
);
	import aopc_pkg::*;

	cw_t nxt;
	logic [NUM_W-1:0] dv;

	assign take = !valid_q || dn_take;
	assign dv = NUM_W'(in_word.ao) << BIT;

	always_comb begin
		nxt = in_word;
		for (int c = 0; c < NCHAN; c++) begin
			if (in_word.rem[c] >= dv) begin
				nxt.rem[c] = in_word.rem[c] - dv;
				nxt.q[c][BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_q <= nxt;
		end
	end

endmodule

[rtl/alpha_over_pixel_compositor.sv]
// Alpha-over pixel compositor: top level with front pipeline, divider chain and output register.
// An accepted word passes through six front stages, eight divider cells (one quotient
// bit each) and one output register to reach its result.
// Throughput is one word per cycle; bubbles close up, and a stalled output
// holds the pipeline only once every stage is full.
// Reset clears all valid flags asynchronously; payload registers are not reset.
module alpha_over_pixel_compositor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] coverage_mask,
	input  logic [7:0] src_red,
	input  logic [7:0] src_green,
	input  logic [7:0] src_blue,
	input  logic [7:0] src_transparency,
	input  logic [7:0] dst_red,
	input  logic [7:0] dst_green,
	input  logic [7:0] dst_blue,
	input  logic [7:0] dst_alpha,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue,
	output logic [7:0] out_alpha
);
	import aopc_pkg::*;

	pix_t pix;
	logic front_take;
	logic [QBITS:0] cv;
	cw_t cw [QBITS+1];
	logic [QBITS:0] ctake;
	logic out_take;
	logic [NCHAN-1:0][7:0] col_d;
	logic [7:0] oa_d;
	cw_t lw;

	assign pix.mask = coverage_mask;
	assign pix.trans = src_transparency;
	assign pix.src = {src_blue, src_green, src_red};
	assign pix.dst = {dst_blue, dst_green, dst_red};
	assign pix.da = dst_alpha;

	assign in_stall = !front_take;

	aopc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_pix   (pix),
		.take     (front_take),
		.dn_take  (ctake[0]),
		.valid_s6 (cv[0]),
		.word_s6  (cw[0])
	);

	for (genvar i = 0; i < QBITS; i++) begin : g_cell
		aopc_div_cell #(.BIT(QBITS - 1 - i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (cv[i]),
			.in_word  (cw[i]),
			.take     (ctake[i]),
			.dn_take  (ctake[i+1]),
			.valid_q  (cv[i+1]),
			.word_q   (cw[i+1])
		);
	end

	assign out_take = !out_valid || !out_stall;
	assign ctake[QBITS] = out_take;
	assign lw = cw[QBITS];

	always_comb begin
		col_d = lw.dst;
		oa_d = lw.da;
		unique case (lw.mode)
			MODE_SRC: begin
				col_d = lw.src;
				oa_d = lw.sa;
			end
			MODE_BLEND: begin
				for (int c = 0; c < NCHAN; c++) begin
					col_d[c] = lw.sat[c] ? FULL_SCALE : lw.q[c];
				end
				oa_d = lw.ao[8] ? FULL_SCALE : lw.ao[7:0];
			end
			default: begin
				col_d = lw.dst;
				oa_d = lw.da;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_take) begin
			out_valid <= cv[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			out_red <= col_d[0];
			out_green <= col_d[1];
			out_blue <= col_d[2];
			out_alpha <= oa_d;
		end
	end

endmodule

[rtl/aopc_chk.sv]
// Port-level checker for the alpha-over pixel compositor and its bind.
`include "assert_macros.svh"

module aopc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic [7:0] out_alpha
);

	`AOPC_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid, "output word dropped while stalled")
	`AOPC_ASSERT(a_out_stable, clk, arst_n, out_valid && out_stall |=> $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_alpha), "stalled output word changed")
	`AOPC_ASSERT(a_stall_cause, clk, arst_n, in_stall |-> out_valid && out_stall, "input stalled while output side is free")
	`AOPC_ASSERT_ALWAYS(a_reset_empty, clk, $rose(arst_n) |-> !out_valid, "output valid right after reset")

endmodule

bind alpha_over_pixel_compositor aopc_chk u_aopc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_red   (out_red),
	.out_green (out_green),
	.out_blue  (out_blue),
	.out_alpha (out_alpha)
);
